>>> hw/rtl/camera_point_projection_radtan_unit_macros.svh
// ----------------------------------------------------------------------------
// Projection unit assertion macros
// Shared concurrent assertion forms, reset-qualified on the active-low reset.
// ----------------------------------------------------------------------------
`ifndef CAMERA_POINT_PROJECTION_RADTAN_UNIT_MACROS_SVH
`define CAMERA_POINT_PROJECTION_RADTAN_UNIT_MACROS_SVH

// Same-cycle implication.
`define CPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpr assertion failed");

// Next-cycle implication.
`define CPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpr assertion failed");

`endif

>>> hw/rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// Projection unit package
// Shared types, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package cpr_pkg;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_FOCAL_X = 4'd0,
        REG_FOCAL_Y = 4'd1,
        REG_CENTER_X = 4'd2,
        REG_CENTER_Y = 4'd3,
        REG_RADIAL_K1 = 4'd4,
        REG_RADIAL_K2 = 4'd5,
        REG_TANG_P1 = 4'd6,
        REG_TANG_P2 = 4'd7
    } t_reg_idx;

    localparam int DIV_STEPS = 32;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [39:0] Q28_ONE = 40'sd268435456;
    localparam logic signed [63:0] Q28_HALF = 64'sd134217728;

    // Divider result handed to the distortion pipeline.
    typedef struct packed {
        logic        zpos;
        logic        sx;
        logic        sy;
        logic        ovx;
        logic        ovy;
        logic [31:0] qx;
        logic [31:0] qy;
    } t_div_res;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < 40'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q4.28 product, rounded half up, saturated.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [35:0] s;
        p = a * b;
        p = p + Q28_HALF;
        s = p[63:28];
        return sat32(40'(s));
    endfunction

endpackage

>>> hw/rtl/cpr_if.sv
// ----------------------------------------------------------------------------
// Projection unit channels
// Request channels for camera points and for projected pixels.
// ----------------------------------------------------------------------------
interface cpr_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface cpr_pixel_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               in_frame;

    modport source (output valid, pixel_u, pixel_v, in_frame, input ready);
    modport sink (input valid, pixel_u, pixel_v, in_frame, output ready);
endinterface

>>> hw/rtl/cpr_div.sv
// ----------------------------------------------------------------------------
// Projection unit depth divider
// Pipelined restoring divider, one quotient bit per stage, x and y in parallel.
// ----------------------------------------------------------------------------
module cpr_div
    import cpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    output logic               o_valid,
    output t_div_res           o_res
);

    logic [DIV_STEPS:0] r_vld;
    logic        r_zpos [0:DIV_STEPS];
    logic        r_sx   [0:DIV_STEPS];
    logic        r_sy   [0:DIV_STEPS];
    logic        r_ovx  [0:DIV_STEPS];
    logic        r_ovy  [0:DIV_STEPS];
    logic [3:0]  r_nibx [0:DIV_STEPS];
    logic [3:0]  r_niby [0:DIV_STEPS];
    logic [30:0] r_d    [0:DIV_STEPS];
    logic [30:0] r_rx   [0:DIV_STEPS];
    logic [30:0] r_ry   [0:DIV_STEPS];
    logic [31:0] r_qx   [0:DIV_STEPS];
    logic [31:0] r_qy   [0:DIV_STEPS];

    logic [31:0] ax;
    logic [31:0] ay;

    // Dividend magnitudes.
    always_comb begin
        ax = i_px[31] ? 32'(-i_px) : i_px;
        ay = i_py[31] ? 32'(-i_py) : i_py;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-1:0], i_valid};
        end
    end

    // Input stage: the top dividend bits form the first partial remainder.
    // The quotient needs more than 32 bits when |p| >= 16*z.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zpos[0] <= !i_pz[31] && (i_pz != 32'sd0);
            r_sx[0]   <= i_px[31];
            r_sy[0]   <= i_py[31];
            r_ovx[0]  <= ({3'b000, ax} >= {i_pz[30:0], 4'b0000});
            r_ovy[0]  <= ({3'b000, ay} >= {i_pz[30:0], 4'b0000});
            r_nibx[0] <= ax[3:0];
            r_niby[0] <= ay[3:0];
            r_d[0]    <= i_pz[30:0];
            r_rx[0]   <= {3'b000, ax[31:4]};
            r_ry[0]   <= {3'b000, ay[31:4]};
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
        end
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic        bx;
        logic        by;
        logic [31:0] tx;
        logic [31:0] ty;
        logic        gx;
        logic        gy;

        always_comb begin
            if (k < 4) begin
                bx = r_nibx[k][3 - (k % 4)];
                by = r_niby[k][3 - (k % 4)];
            end else begin
                bx = 1'b0;
                by = 1'b0;
            end
            tx = {r_rx[k], bx};
            ty = {r_ry[k], by};
            gx = tx >= {1'b0, r_d[k]};
            gy = ty >= {1'b0, r_d[k]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zpos[k+1] <= r_zpos[k];
                r_sx[k+1]   <= r_sx[k];
                r_sy[k+1]   <= r_sy[k];
                r_ovx[k+1]  <= r_ovx[k];
                r_ovy[k+1]  <= r_ovy[k];
                r_nibx[k+1] <= r_nibx[k];
                r_niby[k+1] <= r_niby[k];
                r_d[k+1]    <= r_d[k];
                r_rx[k+1]   <= gx ? 31'(tx - {1'b0, r_d[k]}) : tx[30:0];
                r_ry[k+1]   <= gy ? 31'(ty - {1'b0, r_d[k]}) : ty[30:0];
                r_qx[k+1]   <= {r_qx[k][30:0], gx};
                r_qy[k+1]   <= {r_qy[k][30:0], gy};
            end
        end
    end

    assign o_valid   = r_vld[DIV_STEPS];
    assign o_res.zpos = r_zpos[DIV_STEPS];
    assign o_res.sx   = r_sx[DIV_STEPS];
    assign o_res.sy   = r_sy[DIV_STEPS];
    assign o_res.ovx  = r_ovx[DIV_STEPS];
    assign o_res.ovy  = r_ovy[DIV_STEPS];
    assign o_res.qx   = r_qx[DIV_STEPS];
    assign o_res.qy   = r_qy[DIV_STEPS];

endmodule

>>> hw/rtl/cpr_dist.sv
// ----------------------------------------------------------------------------
// Projection unit distortion and pixel mapping
// Nine-stage multiply pipeline: radial-tangential distortion, focal scaling.
// ----------------------------------------------------------------------------
module cpr_dist
    import cpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_div_res           i_res,
    input  logic [31:0]        i_fx,
    input  logic [31:0]        i_fy,
    input  logic signed [31:0] i_cx,
    input  logic signed [31:0] i_cy,
    input  logic signed [31:0] i_k1,
    input  logic signed [31:0] i_k2,
    input  logic signed [31:0] i_p1,
    input  logic signed [31:0] i_p2,
    output logic               o_valid,
    output logic               o_zpos,
    output logic signed [31:0] o_u,
    output logic signed [31:0] o_v
);

    localparam int NSTG = 9;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] r_zp;

    logic signed [31:0] nx, ny;
    logic signed [31:0] r_nx1, r_ny1, r_x2, r_y2, r_xy;
    logic signed [31:0] r_nx2, r_ny2, r_r2, r_tx, r_ty, r_mp1xy, r_mp2xy;
    logic signed [31:0] r_nx3, r_ny3, r_r4, r_mk1, r_mpa, r_mpb, r_mp1xy3, r_mp2xy3;
    logic signed [31:0] r_nx4, r_ny4, r_mk1b, r_mk2, r_mpa4, r_mpb4, r_mp1xy4, r_mp2xy4;
    logic signed [31:0] r_nx5, r_ny5, r_f, r_mpa5, r_mpb5, r_mp1xy5, r_mp2xy5;
    logic signed [31:0] r_ax, r_ay, r_mpa6, r_mpb6, r_mp1xy6, r_mp2xy6;
    logic signed [31:0] r_xd, r_yd;
    logic signed [37:0] r_pu, r_pv;
    logic signed [31:0] r_u, r_v;

    logic signed [31:0] r2c;
    logic signed [65:0] pu, pv;

    // Normalized coordinates from the divider quotient, with saturation.
    always_comb begin
        if (i_res.ovx) begin
            nx = i_res.sx ? S32_MIN : S32_MAX;
        end else if (i_res.sx) begin
            nx = (i_res.qx > 32'h8000_0000) ? S32_MIN : 32'(-i_res.qx);
        end else begin
            nx = (i_res.qx > 32'h7fff_ffff) ? S32_MAX : i_res.qx;
        end
        if (i_res.ovy) begin
            ny = i_res.sy ? S32_MIN : S32_MAX;
        end else if (i_res.sy) begin
            ny = (i_res.qy > 32'h8000_0000) ? S32_MIN : 32'(-i_res.qy);
        end else begin
            ny = (i_res.qy > 32'h7fff_ffff) ? S32_MAX : i_res.qy;
        end
        r2c = sat32(40'(r_x2) + 40'(r_y2));
        pu  = $signed({1'b0, i_fx}) * r_xd + 66'sd134217728;
        pv  = $signed({1'b0, i_fy}) * r_yd + 66'sd134217728;
    end

    // Valid and depth flags travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zp <= {r_zp[NSTG-2:0], i_res.zpos};
            // Squares and cross term.
            r_nx1 <= nx;
            r_ny1 <= ny;
            r_x2  <= qmul(nx, nx);
            r_y2  <= qmul(ny, ny);
            r_xy  <= qmul(nx, ny);
            // Radius and tangential products on the cross term.
            r_nx2   <= r_nx1;
            r_ny2   <= r_ny1;
            r_r2    <= r2c;
            r_tx    <= sat32(40'(r2c) + (40'(r_x2) <<< 1));
            r_ty    <= sat32(40'(r2c) + (40'(r_y2) <<< 1));
            r_mp1xy <= qmul(i_p1, r_xy);
            r_mp2xy <= qmul(i_p2, r_xy);
            // Fourth power and first radial term.
            r_nx3    <= r_nx2;
            r_ny3    <= r_ny2;
            r_r4     <= qmul(r_r2, r_r2);
            r_mk1    <= qmul(i_k1, r_r2);
            r_mpa    <= qmul(i_p2, r_tx);
            r_mpb    <= qmul(i_p1, r_ty);
            r_mp1xy3 <= r_mp1xy;
            r_mp2xy3 <= r_mp2xy;
            // Second radial term.
            r_nx4    <= r_nx3;
            r_ny4    <= r_ny3;
            r_mk1b   <= r_mk1;
            r_mk2    <= qmul(i_k2, r_r4);
            r_mpa4   <= r_mpa;
            r_mpb4   <= r_mpb;
            r_mp1xy4 <= r_mp1xy3;
            r_mp2xy4 <= r_mp2xy3;
            // Radial factor.
            r_nx5    <= r_nx4;
            r_ny5    <= r_ny4;
            r_f      <= sat32(Q28_ONE + 40'(r_mk1b) + 40'(r_mk2));
            r_mpa5   <= r_mpa4;
            r_mpb5   <= r_mpb4;
            r_mp1xy5 <= r_mp1xy4;
            r_mp2xy5 <= r_mp2xy4;
            // Radial scaling.
            r_ax     <= qmul(r_nx5, r_f);
            r_ay     <= qmul(r_ny5, r_f);
            r_mpa6   <= r_mpa5;
            r_mpb6   <= r_mpb5;
            r_mp1xy6 <= r_mp1xy5;
            r_mp2xy6 <= r_mp2xy5;
            // Distorted point.
            r_xd <= sat32(40'(r_ax) + (40'(r_mp1xy6) <<< 1) + 40'(r_mpa6));
            r_yd <= sat32(40'(r_ay) + (40'(r_mp2xy6) <<< 1) + 40'(r_mpb6));
            // Focal scaling, rounded to Q16.16.
            r_pu <= pu[65:28];
            r_pv <= pv[65:28];
            // Principal point.
            r_u <= sat32(40'(r_pu) + 40'(i_cx));
            r_v <= sat32(40'(r_pv) + 40'(i_cy));
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_zpos  = r_zp[NSTG-1];
    assign o_u     = r_u;
    assign o_v     = r_v;

endmodule

>>> hw/rtl/camera_point_projection_radtan_unit.sv
// A point passes 33 divider stages, 9 distortion stages and the output register
// before its pixel request is presented. Throughput: one point per cycle unless
// the output stalls; the divider dominates latency.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the register
// defaults: unit focal lengths, zero center and zero distortion.
// ----------------------------------------------------------------------------
// Projection unit top level
// Pinhole projection with radtan distortion, one point per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "camera_point_projection_radtan_unit_macros.svh"

module camera_point_projection_radtan_unit
    import cpr_pkg::*;
#(
    parameter int IMAGE_WIDTH = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpr_point_if.sink   i_point,
    cpr_pixel_if.source o_pixel,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam logic signed [31:0] U_LIMIT = 32'(IMAGE_WIDTH * 65536);
    localparam logic signed [31:0] V_LIMIT = 32'(IMAGE_HEIGHT * 65536);

    logic [31:0]        r_fx, r_fy;
    logic signed [31:0] r_cx, r_cy, r_k1, r_k2, r_p1, r_p2;

    logic               en;
    logic               div_vld;
    t_div_res           div_res;
    logic               dst_vld;
    logic               dst_zpos;
    logic signed [31:0] dst_u, dst_v;

    logic               r_out_vld;
    logic signed [31:0] r_out_u, r_out_v;
    logic               r_out_in;

    logic               chk_hit;
    logic               chk_u_ok;
    logic               chk_v_ok;
    logic               chk_stall;

    // The pipeline advances unless a finished request waits at the output.
    assign en = !r_out_vld || o_pixel.ready;
    assign i_point.ready = en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= 32'd65536;
            r_fy <= 32'd65536;
            r_cx <= '0;
            r_cy <= '0;
            r_k1 <= '0;
            r_k2 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FOCAL_X:   r_fx <= i_cfg_data;
                REG_FOCAL_Y:   r_fy <= i_cfg_data;
                REG_CENTER_X:  r_cx <= i_cfg_data;
                REG_CENTER_Y:  r_cy <= i_cfg_data;
                REG_RADIAL_K1: r_k1 <= i_cfg_data;
                REG_RADIAL_K2: r_k2 <= i_cfg_data;
                REG_TANG_P1:   r_p1 <= i_cfg_data;
                REG_TANG_P2:   r_p2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_point.valid),
        .i_px    (i_point.point_x),
        .i_py    (i_point.point_y),
        .i_pz    (i_point.point_z),
        .o_valid (div_vld),
        .o_res   (div_res)
    );

    cpr_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_vld),
        .i_res   (div_res),
        .i_fx    (r_fx),
        .i_fy    (r_fy),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_k1    (r_k1),
        .i_k2    (r_k2),
        .i_p1    (r_p1),
        .i_p2    (r_p2),
        .o_valid (dst_vld),
        .o_zpos  (dst_zpos),
        .o_u     (dst_u),
        .o_v     (dst_v)
    );

    // Output register: zero pixel for points not in front of the camera, frame test.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dst_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_u  <= dst_zpos ? dst_u : 32'sd0;
            r_out_v  <= dst_zpos ? dst_v : 32'sd0;
            r_out_in <= dst_zpos && (dst_u >= 32'sd0) && (dst_u < U_LIMIT)
                     && (dst_v >= 32'sd0) && (dst_v < V_LIMIT);
        end
    end

    assign o_pixel.valid    = r_out_vld;
    assign o_pixel.pixel_u  = r_out_u;
    assign o_pixel.pixel_v  = r_out_v;
    assign o_pixel.in_frame = r_out_in;

    // Terms for the checks on the presented request.
    assign chk_hit   = o_pixel.valid && o_pixel.in_frame;
    assign chk_u_ok  = (o_pixel.pixel_u >= 32'sd0) && (o_pixel.pixel_u < U_LIMIT);
    assign chk_v_ok  = (o_pixel.pixel_v >= 32'sd0) && (o_pixel.pixel_v < V_LIMIT);
    assign chk_stall = o_pixel.valid && !o_pixel.ready;

    // Checks.
    `CPR_ASSERT_NOW(a_in_frame_u, i_clk, i_rst_n, chk_hit, chk_u_ok)
    `CPR_ASSERT_NOW(a_in_frame_v, i_clk, i_rst_n, chk_hit, chk_v_ok)
    `CPR_ASSERT_NOW(a_stall_src, i_clk, i_rst_n, !i_point.ready, chk_stall)
    `CPR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, chk_stall, $stable({r_out_u, r_out_in}))

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Projection unit testbench
// Streams camera points through the projection unit under random sender gaps
// and receiver stalls. Each point is projected by a local fixed-point model
// and every pixel request is compared with the oldest expected pixel.
// ----------------------------------------------------------------------------
import cpr_pkg::*;

typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               in_frame;
} t_pixel;

// Holds the expected pixels and compares arriving ones.
class pixel_scoreboard;
    t_pixel pending[$];
    int     errors;

    // Register copy for the projection model.
    logic [31:0]        fx, fy;
    logic signed [31:0] cx, cy, k1, k2, p1, p2;

    function new();
        errors = 0;
        fx = 32'h0001_0000;
        fy = 32'h0001_0000;
        cx = 0; cy = 0; k1 = 0; k2 = 0; p1 = 0; p2 = 0;
    endfunction

    function void set_reg(t_reg_idx idx, logic [31:0] val);
        case (idx)
            REG_FOCAL_X: fx = val;
            REG_FOCAL_Y: fy = val;
            REG_CENTER_X: cx = val;
            REG_CENTER_Y: cy = val;
            REG_RADIAL_K1: k1 = val;
            REG_RADIAL_K2: k2 = val;
            REG_TANG_P1: p1 = val;
            REG_TANG_P2: p2 = val;
            default: ;
        endcase
    endfunction

    function longint clamp(longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647) r = 64'sd2147483647;
        if (v < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    // Floor division by 2^28 via arithmetic shift.
    function longint q28_floor(longint v);
        return v >>> 28;
    endfunction

    function longint q28_mul(longint a, longint b);
        return clamp(q28_floor(a * b + 64'sd134217728));
    endfunction

    // Note an accepted point and compute its pixel.
    function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
        longint nx, ny, x2, y2, xy, r2, r4, f, xd, yd, u, v, x, y, z;
        t_pixel e;
        x = px; y = py; z = pz;
        if (z <= 0) begin
            e = '0;
        end else begin
            nx = clamp((x <<< 28) / z);
            ny = clamp((y <<< 28) / z);
            x2 = q28_mul(nx, nx);
            y2 = q28_mul(ny, ny);
            xy = q28_mul(nx, ny);
            r2 = clamp(x2 + y2);
            r4 = q28_mul(r2, r2);
            f = clamp(64'sd268435456 + q28_mul(k1, r2) + q28_mul(k2, r4));
            xd = clamp(q28_mul(nx, f) + 2 * q28_mul(p1, xy)
                       + q28_mul(p2, clamp(r2 + 2 * x2)));
            yd = clamp(q28_mul(ny, f) + 2 * q28_mul(p2, xy)
                       + q28_mul(p1, clamp(r2 + 2 * y2)));
            u = clamp(q28_floor(longint'({32'd0, fx}) * xd + 64'sd134217728) + cx);
            v = clamp(q28_floor(longint'({32'd0, fy}) * yd + 64'sd134217728) + cy);
            e.pixel_u = u[31:0];
            e.pixel_v = v[31:0];
            e.in_frame = (u >= 0) && (u < 64'sd1024 * 65536)
                      && (v >= 0) && (v < 64'sd1024 * 65536);
        end
        pending.push_back(e);
    endfunction

    // Compare an arriving pixel with the oldest expected one.
    function void check_pixel(t_pixel got);
        t_pixel e;
        if (pending.size() == 0) begin
            $error("unexpected pixel request u=%0d v=%0d", got.pixel_u, got.pixel_v);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.pixel_u !== e.pixel_u) begin
            $error("pixel_u expected %0d got %0d", e.pixel_u, got.pixel_u);
            errors++;
        end
        if (got.pixel_v !== e.pixel_v) begin
            $error("pixel_v expected %0d got %0d", e.pixel_v, got.pixel_v);
            errors++;
        end
        if (got.in_frame !== e.in_frame) begin
            $error("in_frame expected %0d got %0d", e.in_frame, got.in_frame);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int LATENCY = 43;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    cpr_point_if point_ch();
    cpr_pixel_if pixel_ch();

    pixel_scoreboard sb;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  timed_out = 1'b0;
    bit  stim_done = 1'b0;
    int  burst_left;

    camera_point_projection_radtan_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_point(point_ch.sink),
        .o_pixel(pixel_ch.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stalls on a pattern that shifts between phases.
    always @(posedge i_clk) begin
        int mode;
        mode = ($time / 4000) % 4;
        if (!i_rst_n || hold_off) begin
            pixel_ch.ready <= 1'b0;
        end else begin
            case (mode)
                0: pixel_ch.ready <= 1'b1;
                1: pixel_ch.ready <= ($urandom_range(0, 3) != 0);
                2: pixel_ch.ready <= ($urandom_range(0, 1) == 0);
                default: pixel_ch.ready <= (($time / 10) % 7) < 4;
            endcase
        end
    end

    // Check each accepted pixel request.
    always @(posedge i_clk) begin
        if (i_rst_n && pixel_ch.valid && pixel_ch.ready) begin
            sb.check_pixel({pixel_ch.pixel_u, pixel_ch.pixel_v, pixel_ch.in_frame});
        end
    end

    // Watchdog on cycles without any accepted request.
    always @(posedge i_clk) begin
        if ((point_ch.valid && point_ch.ready) || (pixel_ch.valid && pixel_ch.ready)
                || !i_rst_n || hold_off) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
            end
        end
    end

    // Offer a point, wait until it is accepted; use_gaps adds random burst gaps.
    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz, bit use_gaps);
        if (use_gaps && burst_left == 0) begin
            point_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        point_ch.valid <= 1'b1;
        point_ch.point_x <= px;
        point_ch.point_y <= py;
        point_ch.point_z <= pz;
        do @(posedge i_clk); while (!point_ch.ready);
        sb.note_point(px, py, pz);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic stop_sending();
        point_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic write_all(logic [31:0] v[8]);
        for (int i = 0; i < 8; i++) begin
            write_reg(t_reg_idx'(i), v[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Random point: mostly in front of the camera with moderate spread.
    task automatic random_point();
        logic signed [31:0] px, py, pz;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            pz = $urandom_range(32'h0000_4000, 32'h0040_0000);
            px = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            py = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        end else begin
            px = $urandom;
            py = $urandom;
            pz = $urandom;
        end
        send_point(px, py, pz, 1'b1);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            random_point();
        end
        stop_sending();
        drain();
    endtask

    // Main sequence.
    initial begin
        logic [31:0] cfg[8];
        sb = new();
        burst_left = 0;
        point_ch.valid = 1'b0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        point_ch.point_z = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points at reset defaults.
        send_point(0, 0, 32'sh0001_0000, 1'b0);
        send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 1'b0);
        send_point(5, 7, 0, 1'b0);
        send_point(5, 7, 32'sh8000_0000, 1'b0);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 1, 1'b0);
        send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
        send_point(32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 1'b0);
        send_point(32'sh0000_8000, 32'sh0000_4000, 32'sh0001_0000, 1'b0);
        stop_sending();
        drain();

        // Typical camera with distortion.
        cfg = '{32'h0200_0000, 32'h01f0_0000, 32'h0200_0000, 32'h0200_0000,
                32'shfc00_0000, 32'h0100_0000, 32'h0008_0000, 32'shfff8_0000};
        write_all(cfg);
        send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0004_0000, 1'b0);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh0000_0001, 1'b0);
        send_point(-32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000, 1'b0);
        send_point(32'sh0040_0000, -32'sh0040_0000, 32'sh0001_0000, 1'b0);
        stop_sending();
        drain();

        // Long receiver hold-off while points keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(200);
        join

        // Extreme register values.
        cfg = '{32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        write_all(cfg);
        send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0100, 1'b0);
        random_phase(100);

        cfg = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        write_all(cfg);
        random_phase(100);

        // Random settings.
        for (int s = 0; s < 6; s++) begin
            cfg[0] = $urandom_range(32'h0001_0000, 32'h0400_0000);
            cfg[1] = $urandom_range(32'h0001_0000, 32'h0400_0000);
            cfg[2] = $urandom_range(0, 32'h0400_0000);
            cfg[3] = $urandom_range(0, 32'h0400_0000);
            for (int r = 4; r < 8; r++) begin
                cfg[r] = ($urandom_range(0, 3) == 0) ? $urandom
                       : $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
            end
            write_all(cfg);
            random_phase(110);
        end
        stim_done = 1'b1;
    end

    // Final verdict once the stimulus has drained, or on a timeout.
    initial begin
        fork
            wait (timed_out);
            wait (stim_done);
        join_any
        if (timed_out) begin
            $display("Some tests failed");
        end else if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_if.sv
hw/rtl/cpr_div.sv
hw/rtl/cpr_dist.sv
hw/rtl/camera_point_projection_radtan_unit.sv
bench/tb.sv
